// ===== rtl/lps3_pkg.sv =====
// Package for the 3x3 Laplacian sharpening filter.
// Word types, configuration register codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package lps3_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;

    // Stored pixel, blue in the low byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_bgr;

    typedef struct packed {
        logic       flush;
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       frame_last;
    } t_pix_out;

endpackage

// ===== rtl/lps3_stream_if.sv =====
// Valid/ready stream interface carrying one word of type t_data.
// Uses no package.
`timescale 1ns / 1ps

interface lps3_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lps3_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lps3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/laplacian_sharpen_3x3_top.sv =====
// 3x3 Laplacian sharpening filter for a BGR raster stream, reflect-101 borders.
// Depends on lps3_pkg, lps3_stream_if and lps3_ram.
`timescale 1ns / 1ps
//
//  channel   dir  word       fields
//  i_pix     in   t_pix_in   flush, blue_in, green_in, red_in
//  o_pix     out  t_pix_out  blue_out, green_out, red_out, frame_last
//  i_cfg_*   in   write      0: image_width, 1: image_height
//
// One word accepted per clock while i_pix.ready is high; a result enters the output
// queue as the word that causes it is taken. The rate is set by the line store RAMs,
// whose next column is read ahead while the current word is taken.
// A two-entry output queue lets one more word in while a result waits; i_pix.ready
// drops only when both entries are full.
// Synchronous active-low reset clears counters and queue count and loads the default size;
// window, queue words and line stores hold garbage. A frame ends with eff_w+1 drain words.

module laplacian_sharpen_3x3_top #(
    parameter int MAX_WIDTH = lps3_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lps3_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lps3_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lps3_stream_if.sink                      i_pix,
    lps3_stream_if.source                    o_pix
);

    localparam int CW = $clog2(MAX_WIDTH);       // column index
    localparam int WW = $clog2(MAX_WIDTH + 1);   // width value
    localparam int PW = $clog2(MAX_WIDTH + 2);   // drain count

    typedef enum logic [1:0] {
        COL_RIGHT_EDGE,   // cols 1,2,1
        COL_LEFT_EDGE,    // cols 2,1,2
        COL_INNER         // cols 0,1,2
    } t_colmode;

    // Registers
    logic [lps3_pkg::WIDTH_W-1:0]  r_cfg_w;
    logic [lps3_pkg::HEIGHT_W-1:0] r_cfg_h;
    logic [CW-1:0]                 r_col, n_col;
    logic [15:0]                   r_row, n_row;
    logic [PW-1:0]                 r_pend, n_pend;
    lps3_pkg::t_bgr [2:0][2:0]     r_win;        // [row top..bottom][col oldest..newest]
    lps3_pkg::t_pix_out            r_q0, r_q1;
    logic [1:0]                    r_qcnt;

    // Combinational
    logic [WW-1:0]                 eff_w;
    logic [15:0]                   eff_h;
    logic [WW-1:0]                 col_inc;
    logic                          accept, draining, pop;
    lps3_pkg::t_bgr                px, rd_up, rd_mid;
    lps3_pkg::t_bgr [2:0]          col_new;
    lps3_pkg::t_bgr [2:0][2:0]     win_new, win_sel;
    lps3_pkg::t_bgr [2:0]          row_t, row_m, row_b;
    lps3_pkg::t_bgr [2:0][2:0]     taps;
    logic [8:0][7:0]               ch_b, ch_g, ch_r;
    logic                          do_shift, st_we, push, post, top_ref, bot_ref, last;
    t_colmode                      cmode;
    lps3_pkg::t_pix_out            res;

    function automatic logic [7:0] f_sharpen(input logic [8:0][7:0] p);
        logic [11:0]        c9;
        logic [10:0]        s8;
        logic signed [12:0] acc;
        c9  = {1'b0, p[4], 3'b000} + 12'(p[4]);
        s8  = 11'(p[0]) + 11'(p[1]) + 11'(p[2]) + 11'(p[3])
            + 11'(p[5]) + 11'(p[6]) + 11'(p[7]) + 11'(p[8]);
        acc = $signed({1'b0, c9}) - $signed({2'b00, s8});
        if (acc < 13'sd0) begin
            return 8'd0;
        end else if (acc > 13'sd255) begin
            return 8'd255;
        end
        return acc[7:0];
    endfunction

    // Effective geometry
    always_comb begin
        if (r_cfg_w < 12'd3) begin
            eff_w = WW'(3);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        eff_h = (r_cfg_h < 16'd2) ? 16'd2 : r_cfg_h;
    end

    assign i_pix.ready = (r_qcnt != 2'd2);
    assign accept      = i_pix.valid && i_pix.ready;
    assign draining    = (r_pend != '0);
    assign pop         = o_pix.valid && o_pix.ready;
    assign col_inc     = WW'(r_col) + WW'(1);

    assign px = '{red: i_pix.data.red_in, green: i_pix.data.green_in,
                  blue: i_pix.data.blue_in};

    // Line stores; the read address runs one column ahead of the window
    lps3_ram #(.WIDTH($bits(lps3_pkg::t_bgr)), .DEPTH(MAX_WIDTH)) u_store_up (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_col),
        .i_wdata (rd_mid),
        .i_raddr (n_col),
        .o_rdata (rd_up)
    );

    lps3_ram #(.WIDTH($bits(lps3_pkg::t_bgr)), .DEPTH(MAX_WIDTH)) u_store_mid (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_col),
        .i_wdata (px),
        .i_raddr (n_col),
        .o_rdata (rd_mid)
    );

    // Window after a shift
    always_comb begin
        col_new[0] = rd_up;
        col_new[1] = rd_mid;
        col_new[2] = draining ? lps3_pkg::t_bgr'('0) : px;
        for (int r = 0; r < 3; r++) begin
            win_new[r][0] = r_win[r][1];
            win_new[r][1] = r_win[r][2];
            win_new[r][2] = col_new[r];
        end
    end

    // Sequencing: counters, shift, store write and which taps form the result
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_pend   = r_pend;
        do_shift = 1'b0;
        st_we    = 1'b0;
        push     = 1'b0;
        post     = 1'b0;
        cmode    = COL_INNER;
        top_ref  = 1'b0;
        bot_ref  = 1'b0;
        last     = 1'b0;
        if (accept) begin
            if (draining) begin
                push = 1'b1;
                if (r_pend == PW'(1)) begin
                    // last pixel of the bottom row
                    cmode   = COL_RIGHT_EDGE;
                    bot_ref = 1'b1;
                    last    = 1'b1;
                    n_pend  = '0;
                    n_col   = '0;
                    n_row   = '0;
                end else begin
                    do_shift = 1'b1;
                    n_col    = r_col + CW'(1);
                    n_pend   = r_pend - PW'(1);
                    if (r_col == '0) begin
                        cmode   = COL_RIGHT_EDGE;
                        top_ref = (eff_h == 16'd2);
                    end else begin
                        post    = 1'b1;
                        bot_ref = 1'b1;
                        cmode   = (r_col == CW'(1)) ? COL_LEFT_EDGE : COL_INNER;
                    end
                end
            end else if (!i_pix.data.flush) begin
                do_shift = 1'b1;
                st_we    = 1'b1;
                if (r_col == '0 && r_row >= 16'd2) begin
                    // right edge of the row two back
                    push    = 1'b1;
                    cmode   = COL_RIGHT_EDGE;
                    top_ref = (r_row == 16'd2);
                    bot_ref = ({1'b0, r_row} >= ({1'b0, eff_h} + 17'd1));
                end
                if (r_col != '0 && r_row != 16'd0) begin
                    push    = 1'b1;
                    post    = 1'b1;
                    cmode   = (r_col == CW'(1)) ? COL_LEFT_EDGE : COL_INNER;
                    top_ref = (r_row == 16'd1);
                    bot_ref = (r_row >= eff_h);
                end
                if (col_inc >= eff_w) begin
                    n_col = '0;
                    if (({1'b0, r_row} + 17'd1) >= {1'b0, eff_h}) begin
                        n_pend = PW'(eff_w) + PW'(1);
                        n_row  = '0;
                    end else begin
                        n_row = r_row + 16'd1;
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    // Filter taps and arithmetic
    always_comb begin
        win_sel = post ? win_new : r_win;
        row_t   = top_ref ? win_sel[2] : win_sel[0];
        row_m   = win_sel[1];
        row_b   = bot_ref ? win_sel[0] : win_sel[2];
        case (cmode)
            COL_RIGHT_EDGE: begin
                taps[0] = '{row_t[1], row_t[2], row_t[1]};
                taps[1] = '{row_m[1], row_m[2], row_m[1]};
                taps[2] = '{row_b[1], row_b[2], row_b[1]};
            end
            COL_LEFT_EDGE: begin
                taps[0] = '{row_t[2], row_t[1], row_t[2]};
                taps[1] = '{row_m[2], row_m[1], row_m[2]};
                taps[2] = '{row_b[2], row_b[1], row_b[2]};
            end
            default: begin
                taps[0] = '{row_t[2], row_t[1], row_t[0]};
                taps[1] = '{row_m[2], row_m[1], row_m[0]};
                taps[2] = '{row_b[2], row_b[1], row_b[0]};
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ch_b[i*3+j] = taps[i][j].blue;
                ch_g[i*3+j] = taps[i][j].green;
                ch_r[i*3+j] = taps[i][j].red;
            end
        end
        res.blue_out   = f_sharpen(ch_b);
        res.green_out  = f_sharpen(ch_g);
        res.red_out    = f_sharpen(ch_r);
        res.frame_last = last;
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= lps3_pkg::WIDTH_RST;
            r_cfg_h <= lps3_pkg::HEIGHT_RST;
            r_col   <= '0;
            r_row   <= '0;
            r_pend  <= '0;
            r_qcnt  <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lps3_pkg::CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data[lps3_pkg::WIDTH_W-1:0];
                    lps3_pkg::CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data[lps3_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
            if (push && !pop) begin
                r_qcnt <= r_qcnt + 2'd1;
            end else if (pop && !push) begin
                r_qcnt <= r_qcnt - 2'd1;
            end
        end
    end

    // Window and output queue payload
    always_ff @(posedge i_clk) begin
        if (do_shift) begin
            r_win <= win_new;
        end
        if (push && pop) begin
            if (r_qcnt == 2'd2) begin
                r_q0 <= r_q1;
                r_q1 <= res;
            end else begin
                r_q0 <= res;
            end
        end else if (push) begin
            if (r_qcnt == 2'd0) begin
                r_q0 <= res;
            end else begin
                r_q1 <= res;
            end
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    assign o_pix.valid = (r_qcnt != 2'd0);
    assign o_pix.data  = r_q0;

endmodule

// ===== rtl/lps3_checker.sv =====
// Port-level checks for laplacian_sharpen_3x3_top, attached by bind.
// Depends on lps3_pkg and the top level's ports.
`timescale 1ns / 1ps

module lps3_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input lps3_pkg::t_pix_out i_out_data
);

    // A waiting result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed or vanished while stalled");

    // Input side never blocks with an empty output queue
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while no result is pending");

    // Input back-pressure only follows an output stall
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("input ready dropped without an output stall");

    // A result only appears after an input word was taken
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result appeared without an accepted input word");

endmodule

bind laplacian_sharpen_3x3_top lps3_checker u_lps3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  (o_pix.data)
);

// ===== test/testbench.sv =====
// Self-checking bench for laplacian_sharpen_3x3_top: streams BGR frames through the
// filter and compares every result word against an in-bench sharpening predictor.
// Depends on lps3_pkg, lps3_stream_if and the top level of the filter.
`timescale 1ns / 1ps

module testbench;
    import lps3_pkg::*;

    localparam int MAXW = MAX_WIDTH_DEF;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    lps3_stream_if #(.t_data(t_pix_in))  pix_if ();
    lps3_stream_if #(.t_data(t_pix_out)) res_if ();

    laplacian_sharpen_3x3_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_pix      (res_if)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------
    // Sharpening predictor: own copy of line stores, window and counters
    // ---------------------------------------------------------------
    t_bgr            line_up  [MAXW];
    t_bgr            line_mid [MAXW];
    t_bgr            win [3][3];       // [top, mid, bottom][oldest .. newest]
    logic [11:0]     width_reg  = WIDTH_RST;
    logic [15:0]     height_reg = HEIGHT_RST;
    int unsigned     col_cnt  = 0;
    int unsigned     row_cnt  = 0;
    int unsigned     pend_cnt = 0;   // nonzero while the frame drains

    t_pix_in         pix_word_q [$];
    t_pix_out        sharpened_q [$];
    int              mismatches = 0;
    int              fed_words  = 0;
    bit              gaps_off   = 1'b0;
    int              cur_w = 640;
    int              cur_h = 480;

    function automatic int clamp_w(logic [11:0] v);
        if (v < 3)
            return 3;
        if (v > MAXW)
            return MAXW;
        return int'(v);
    endfunction

    function automatic int clamp_h(logic [15:0] v);
        return (v < 2) ? 2 : int'(v);
    endfunction

    function automatic int unsigned store_idx(int unsigned c);
        return (c >= MAXW) ? MAXW - 1 : c;
    endfunction

    function automatic logic [7:0] sat8(int a);
        if (a < 0)
            return 8'd0;
        if (a > 255)
            return 8'd255;
        return a[7:0];
    endfunction

    function automatic void push_column(t_bgr t, t_bgr m, t_bgr b);
        t_bgr v [3];
        v[0] = t;
        v[1] = m;
        v[2] = b;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
            win[r][2] = v[r];
        end
    endfunction

    // 9*centre minus the 8 neighbours; mirrored rows swap top and bottom
    function automatic t_pix_out laplace_at(int lc, int cc, int rc, bit top_ref,
                                            bit bot_ref, bit last);
        int       rsel [3];
        int       csel [3];
        int       acc_b, acc_g, acc_r, wt;
        t_bgr     p;
        t_pix_out res;
        rsel[0] = top_ref ? 2 : 0;
        rsel[1] = 1;
        rsel[2] = bot_ref ? 0 : 2;
        csel = '{lc, cc, rc};
        acc_b = 0;
        acc_g = 0;
        acc_r = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p  = win[rsel[i]][csel[j]];
                wt = (i == 1 && j == 1) ? 9 : -1;
                acc_b += wt * int'(p.blue);
                acc_g += wt * int'(p.green);
                acc_r += wt * int'(p.red);
            end
        end
        res.blue_out   = sat8(acc_b);
        res.green_out  = sat8(acc_g);
        res.red_out    = sat8(acc_r);
        res.frame_last = last;
        return res;
    endfunction

    function automatic void drain_one();
        int unsigned ht, k, i;
        ht = clamp_h(height_reg);
        k  = col_cnt;
        if (pend_cnt <= 1) begin
            sharpened_q.push_back(laplace_at(1, 2, 1, ht == 1, 1'b1, 1'b1));
            pend_cnt = 0;
            col_cnt  = 0;
            row_cnt  = 0;
            return;
        end
        i = store_idx(k);
        if (k == 0) begin
            sharpened_q.push_back(laplace_at(1, 2, 1, ht == 2, 1'b0, 1'b0));
            push_column(line_up[i], line_mid[i], '0);
        end else begin
            push_column(line_up[i], line_mid[i], '0);
            if (k == 1)
                sharpened_q.push_back(laplace_at(2, 1, 2, 1'b0, 1'b1, 1'b0));
            else
                sharpened_q.push_back(laplace_at(0, 1, 2, 1'b0, 1'b1, 1'b0));
        end
        col_cnt  = k + 1;
        pend_cnt = pend_cnt - 1;
    endfunction

    function automatic void sharpen_step(t_pix_in w);
        int unsigned wd, ht, c, r, i;
        t_bgr        px, up, mid;
        if (pend_cnt != 0) begin
            drain_one();    // any word during a drain acts as a flush
            return;
        end
        if (w.flush)
            return;
        wd = clamp_w(width_reg);
        ht = clamp_h(height_reg);
        c  = col_cnt;
        r  = row_cnt;
        px.blue  = w.blue_in;
        px.green = w.green_in;
        px.red   = w.red_in;
        // right edge of the row two back, emitted at the start of a new row
        if (c == 0 && r >= 2)
            sharpened_q.push_back(laplace_at(1, 2, 1, r == 2, r - 1 >= ht, 1'b0));
        i   = store_idx(c);
        up  = line_up[i];
        mid = line_mid[i];
        line_up[i]  = mid;
        line_mid[i] = px;
        push_column(up, mid, px);
        if (c >= 1 && r >= 1) begin
            if (c == 1)
                sharpened_q.push_back(laplace_at(2, 1, 2, r == 1, r >= ht, 1'b0));
            else
                sharpened_q.push_back(laplace_at(0, 1, 2, r == 1, r >= ht, 1'b0));
        end
        if (c + 1 >= wd) begin
            col_cnt = 0;
            if (r + 1 >= ht) begin
                pend_cnt = wd + 1;
                row_cnt  = 0;
            end else begin
                row_cnt = (r + 1) & 16'hFFFF;
            end
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: feeds pix_word_q, predicts each accepted word
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            pix_if.data  <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_IDX_WIDTH)
                    width_reg = cfg_data[11:0];
                else
                    height_reg = cfg_data;
            end
            if (pix_if.valid && pix_if.ready)
                sharpen_step(pix_if.data);
            if (!pix_if.valid || pix_if.ready) begin
                if (pix_word_q.size() != 0 && (gaps_off || $urandom_range(99) >= 9)) begin
                    pix_if.valid <= 1'b1;
                    pix_if.data  <= pix_word_q.pop_front();
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random backpressure, field-wise compare with oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pix_out want, got;
        bit       bad;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (sharpened_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 100)
                        $display("%0t: result with none pending: got b=%0d g=%0d r=%0d last=%0b",
                                 $time, got.blue_out, got.green_out, got.red_out,
                                 got.frame_last);
                end else begin
                    want = sharpened_q.pop_front();
                    bad  = (got.blue_out !== want.blue_out) ||
                           (got.green_out !== want.green_out) ||
                           (got.red_out !== want.red_out) ||
                           (got.frame_last !== want.frame_last);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 100)
                            $display("%0t: mismatch: expected b=%0d g=%0d r=%0d last=%0b, got b=%0d g=%0d r=%0d last=%0b",
                                     $time, want.blue_out, want.green_out, want.red_out,
                                     want.frame_last, got.blue_out, got.green_out,
                                     got.red_out, got.frame_last);
                    end
                end
            end
            res_if.ready <= gaps_off || $urandom_range(99) >= 9;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_word(bit fl, logic [23:0] bgr);
        t_pix_in w;
        w.flush    = fl;
        w.blue_in  = bgr[7:0];
        w.green_in = bgr[15:8];
        w.red_in   = bgr[23:16];
        pix_word_q.push_back(w);
    endtask

    task automatic push_pixels(int n, bit harsh);
        logic [23:0] v;
        for (int i = 0; i < n; i++) begin
            v = 24'($urandom);
            // saturating patterns: every channel black or white
            if (harsh)
                for (int b = 0; b < 3; b++)
                    v[8*b +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
            push_word(1'b0, v);
            fed_words++;
        end
    endtask

    // w+1 drain words, a few of them pixels that get dropped
    task automatic push_drain(int w);
        for (int i = 0; i <= w; i++) begin
            push_word($urandom_range(99) >= 15, 24'($urandom));
            fed_words++;
        end
    endtask

    task automatic wait_quiet();
        while (pix_word_q.size() != 0 || pix_if.valid)
            @(negedge i_clk);
        while (sharpened_q.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_IDX_WIDTH)
            cur_w = clamp_w(data[11:0]);
        else
            cur_h = clamp_h(data);
    endtask

    function automatic logic [15:0] pick_width();
        int          r;
        logic [15:0] v;
        r = $urandom_range(99);
        if (r < 10)
            v = 16'($urandom_range(0, 2));
        else if (r < 80)
            v = 16'($urandom_range(3, 10));
        else
            v = 16'($urandom_range(11, 40));
        v[15:12] = 4'($urandom_range(15));   // upper bits are not part of the width
        return v;
    endfunction

    function automatic logic [15:0] pick_height();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'($urandom_range(0, 1));
        if (r < 85)
            return 16'($urandom_range(2, 6));
        return 16'($urandom_range(7, 16));
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int kind, k, j, wn, h, rows_left, this_row;
        bit harsh;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        res_if.ready = 1'b0;
        for (int i = 0; i < MAXW; i++) begin
            line_up[i]  = '0;
            line_mid[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // smallest frame, saturating both ways, stray flush, pixel inside a drain
        write_reg(CFG_IDX_WIDTH, 16'd3);
        write_reg(CFG_IDX_HEIGHT, 16'd2);
        push_word(1'b1, 24'h5A5A5A);
        push_word(1'b0, 24'h000000);
        push_word(1'b0, 24'hFFFFFF);
        push_word(1'b0, 24'h000000);
        push_word(1'b0, 24'hFFFFFF);
        push_word(1'b0, 24'h000000);
        push_word(1'b0, 24'h80FF01);
        push_word(1'b1, 24'h000000);
        push_word(1'b0, 24'h123456);
        push_word(1'b1, 24'hFFFFFF);
        push_word(1'b1, 24'h000000);
        wait_quiet();

        // widest row: width above the limit clamps, height below 2 clamps
        write_reg(CFG_IDX_WIDTH, 16'h0FFF);
        write_reg(CFG_IDX_HEIGHT, 16'd1);
        push_pixels(cur_w * cur_h, 1'b0);
        push_drain(cur_w);
        wait_quiet();

        fed_words = 0;
        write_reg(CFG_IDX_WIDTH, pick_width());
        write_reg(CFG_IDX_HEIGHT, pick_height());
        while (fed_words < 1900) begin
            gaps_off = (fed_words >= 700 && fed_words < 1100);
            kind  = $urandom_range(99);
            harsh = ($urandom_range(3) == 0);
            if (kind < 80) begin
                if ($urandom_range(99) < 35) begin
                    wait_quiet();
                    write_reg(CFG_IDX_WIDTH, pick_width());
                    write_reg(CFG_IDX_HEIGHT, pick_height());
                end else begin
                    while (pix_word_q.size() > 4)
                        @(negedge i_clk);
                end
                if ($urandom_range(3) == 0)
                    for (int n = $urandom_range(1, 3); n > 0; n--)
                        push_word(1'b1, 24'($urandom));
                push_pixels(cur_w * cur_h, harsh);
                push_drain(cur_w);
            end else if (kind < 87) begin
                // tall frame cut short by a height write at a row boundary
                wait_quiet();
                write_reg(CFG_IDX_WIDTH, 16'($urandom_range(3, 10)));
                write_reg(CFG_IDX_HEIGHT,
                          $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(20, 1000)));
                k = $urandom_range(2, 4);
                push_pixels(k * cur_w, harsh);
                wait_quiet();
                write_reg(CFG_IDX_HEIGHT, 16'($urandom_range(0, k + 3)));
                rows_left = ((cur_h - 1 > k) ? cur_h - 1 : k) - k + 1;
                push_pixels(rows_left * cur_w, harsh);
                push_drain(cur_w);
            end else if (kind < 94) begin
                // rows of a new width, no wider than before, from a row boundary on
                wait_quiet();
                write_reg(CFG_IDX_WIDTH, 16'($urandom_range(4, 12)));
                write_reg(CFG_IDX_HEIGHT, 16'($urandom_range(4, 8)));
                k = $urandom_range(2, cur_h - 1);
                h = cur_h;
                push_pixels(k * cur_w, harsh);
                wait_quiet();
                wn = $urandom_range(0, cur_w);
                write_reg(CFG_IDX_WIDTH, 16'(wn));
                push_pixels((h - k) * cur_w, harsh);
                push_drain(cur_w);
            end else begin
                // width rewritten, no larger than before, in the middle of a row
                wait_quiet();
                write_reg(CFG_IDX_WIDTH, 16'($urandom_range(5, 12)));
                write_reg(CFG_IDX_HEIGHT, 16'($urandom_range(4, 8)));
                k = $urandom_range(2, cur_h - 2);
                j = $urandom_range(1, cur_w - 1);
                push_pixels(k * cur_w + j, harsh);
                wait_quiet();
                wn = $urandom_range(0, cur_w);
                write_reg(CFG_IDX_WIDTH, 16'(wn));
                // row ends once the column reaches the new width, at least one more pixel
                this_row = ((j + 1 > cur_w) ? j + 1 : cur_w) - j;
                push_pixels(this_row + (cur_h - k - 1) * cur_w, harsh);
                push_drain(cur_w);
            end
        end
        gaps_off = 1'b0;

        wait_quiet();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && sharpened_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
